### rtl/neighbor_table_with_aging_assert.svh
// Assertion macros for the neighbor table
`ifndef NEIGHBOR_TABLE_WITH_AGING_ASSERT_SVH
`define NEIGHBOR_TABLE_WITH_AGING_ASSERT_SVH
// implication checked on every clock edge outside reset
`define NTA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define NTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/nta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nta_pkg;
    localparam int NtaNeighbors     = 16;
    localparam int NtaPorts         = 4;
    localparam int NtaHelloInterval = 5;
    localparam int NtaAgeStep       = 3;
    localparam int NtaLifeFactor    = 3;
    localparam int NtaCfgRegs       = 8;
    localparam int NtaQueueDepth    = 2;

    localparam logic [1:0] FUNC_HELLO  = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_ADVERT = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic [2:0] ST_REFRESHED = 3'd0;
    localparam logic [2:0] ST_ADDED     = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_AGED      = 3'd3;
    localparam logic [2:0] ST_ADVERT    = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  port_index;
        logic [31:0] sender_id;
        logic [31:0] sender_addr;
        logic [31:0] sender_netmask;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] adv_network;
        logic [31:0] adv_netmask;
        logic [31:0] adv_router;
        logic [4:0]  removed_count;
        logic [4:0]  live_count;
        logic        last;
    } res_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HSCAN,
        BK_TSCAN,
        BK_APORT,
        BK_ASCAN
    } bk_state_t;
endpackage
`default_nettype wire

### rtl/nta_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface nta_in_if;
    import nta_pkg::*;
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface nta_out_if;
    import nta_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface nta_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

### rtl/nta_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Accepts items, drops those with function code FUNC_NONE, queues the rest.
module nta_front
    import nta_pkg::*;
#(
    parameter int DEPTH = NtaQueueDepth
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_data,
    output logic      q_valid,
    input  wire logic q_pop,
    output cmd_t      q_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          push;

    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign push     = in_valid && in_ready && (in_data.func != FUNC_NONE);
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (q_pop)
        begin
            rp_next = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end
endmodule
`default_nettype wire

### rtl/nta_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Carries out one queued item by walking the slots, one slot a cycle unless a held result stalls the walk.
module nta_back
    import nta_pkg::*;
#(
    parameter int NEIGHBORS      = NtaNeighbors,
    parameter int PORTS          = NtaPorts,
    parameter int HELLO_INTERVAL = NtaHelloInterval,
    parameter int AGE_STEP       = NtaAgeStep
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire cmd_t        q_data,
    output logic             q_pop,
    input  wire logic [31:0] port_addr [4],
    input  wire logic [31:0] port_mask [4],
    output logic             res_valid,
    input  wire logic        res_ready,
    output res_t             res_data,
    output logic             busy
);
    localparam int IW = $clog2(NEIGHBORS);
    localparam int CW = $clog2(NEIGHBORS + 1);
    localparam logic [7:0] LIFE_INIT = 8'(NtaLifeFactor * HELLO_INTERVAL);
    localparam logic [7:0] STEP      = 8'(AGE_STEP);

    logic [NEIGHBORS-1:0] valid_reg, valid_next;
    logic [1:0]           sport_reg  [NEIGHBORS];
    logic [1:0]           sport_next [NEIGHBORS];
    logic [31:0]          sid_reg    [NEIGHBORS];
    logic [31:0]          sid_next   [NEIGHBORS];
    logic [31:0]          saddr_reg  [NEIGHBORS];
    logic [31:0]          saddr_next [NEIGHBORS];
    logic [31:0]          smask_reg  [NEIGHBORS];
    logic [31:0]          smask_next [NEIGHBORS];
    logic [7:0]           slife_reg  [NEIGHBORS];
    logic [7:0]           slife_next [NEIGHBORS];
    logic [CW-1:0]        pcnt_reg   [4];
    logic [CW-1:0]        pcnt_next  [4];
    logic [CW-1:0]        live_reg, live_next;

    bk_state_t     state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic [CW-1:0] idx_reg, idx_next, wr_reg, wr_next, rem_reg, rem_next;
    logic [CW-1:0] rec_reg, rec_next;
    logic [1:0]    port_reg, port_next;
    res_t          out_reg, out_next;
    logic          out_vld_reg, out_vld_next;

    logic [IW-1:0] ix, wx, lx;
    logic          at_end, out_free, hit, port_bad, last_port, nbr_match, final_rec;
    logic [1:0]    cur_port;

    assign ix        = idx_reg[IW-1:0];
    assign wx        = wr_reg[IW-1:0];
    assign lx        = live_reg[IW-1:0];
    assign at_end    = (idx_reg == CW'(NEIGHBORS));
    assign out_free  = !out_vld_reg || res_ready;
    assign hit       = valid_reg[ix] && sport_reg[ix] == cmd_reg.port_index
                       && sid_reg[ix] == cmd_reg.sender_id;
    assign port_bad  = (32'(cmd_reg.port_index) >= PORTS);
    assign last_port = (port_reg == 2'(PORTS - 1));
    assign cur_port  = port_reg;
    assign nbr_match = valid_reg[ix] && sport_reg[ix] == cur_port;
    // final advert record: last port and this is the last neighbor record of it
    assign final_rec = last_port && (rec_reg + 1'b1 == pcnt_reg[cur_port]);
    assign res_valid = out_vld_reg;
    assign res_data  = out_reg;
    assign busy      = (state_reg != BK_IDLE) || out_vld_reg;
    assign q_pop     = (state_reg == BK_IDLE) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_data.func)
                        FUNC_HELLO:  state_next = BK_HSCAN;
                        FUNC_TICK:   state_next = BK_TSCAN;
                        default:     state_next = BK_APORT;
                    endcase
                end
            end
            BK_HSCAN:
            begin
                if (out_free && (at_end || hit || port_bad))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_TSCAN:
            begin
                if (at_end && out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_APORT:
            begin
                if (out_free)
                begin
                    if (pcnt_reg[cur_port] != '0)
                    begin
                        state_next = BK_ASCAN;
                    end
                    else if (last_port)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_ASCAN:
            begin
                if (out_free)
                begin
                    if (at_end)
                    begin
                        state_next = last_port ? BK_IDLE : BK_APORT;
                    end
                    else if (nbr_match && final_rec)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        valid_next   = valid_reg;
        sport_next   = sport_reg;
        sid_next     = sid_reg;
        saddr_next   = saddr_reg;
        smask_next   = smask_reg;
        slife_next   = slife_reg;
        pcnt_next    = pcnt_reg;
        live_next    = live_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        wr_next      = wr_reg;
        rem_next     = rem_reg;
        rec_next     = rec_reg;
        port_next    = port_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !res_ready;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next  = q_data;
                    idx_next  = '0;
                    wr_next   = '0;
                    rem_next  = '0;
                    rec_next  = '0;
                    port_next = '0;
                end
            end
            BK_HSCAN:
            begin
                if (out_free)
                begin
                    out_next            = '0;
                    out_next.last       = 1'b1;
                    out_next.live_count = 5'(live_reg);
                    if (port_bad)
                    begin
                        out_next.status = ST_DROPPED;
                        out_vld_next    = 1'b1;
                    end
                    else if (!at_end && hit)
                    begin
                        slife_next[ix]  = LIFE_INIT;
                        out_next.status = ST_REFRESHED;
                        out_vld_next    = 1'b1;
                    end
                    else if (at_end)
                    begin
                        out_vld_next = 1'b1;
                        if (live_reg == CW'(NEIGHBORS))
                        begin
                            out_next.status = ST_DROPPED;
                        end
                        else
                        begin
                            // new neighbor goes right after the packed live slots
                            valid_next[lx] = 1'b1;
                            sport_next[lx] = cmd_reg.port_index;
                            sid_next[lx]   = cmd_reg.sender_id;
                            saddr_next[lx] = cmd_reg.sender_addr;
                            smask_next[lx] = cmd_reg.sender_netmask;
                            slife_next[lx] = LIFE_INIT;
                            pcnt_next[cmd_reg.port_index] =
                                pcnt_reg[cmd_reg.port_index] + 1'b1;
                            live_next           = live_reg + 1'b1;
                            out_next.status     = ST_ADDED;
                            out_next.live_count = 5'(live_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            BK_TSCAN:
            begin
                if (!at_end)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (valid_reg[ix])
                    begin
                        // survivors slide down to wx; wx never passes ix
                        valid_next[ix] = 1'b0;
                        if (slife_reg[ix] <= STEP)
                        begin
                            rem_next = rem_reg + 1'b1;
                            if (pcnt_reg[sport_reg[ix]] != '0)
                            begin
                                pcnt_next[sport_reg[ix]] = pcnt_reg[sport_reg[ix]] - 1'b1;
                            end
                        end
                        else
                        begin
                            valid_next[wx] = 1'b1;
                            sport_next[wx] = sport_reg[ix];
                            sid_next[wx]   = sid_reg[ix];
                            saddr_next[wx] = saddr_reg[ix];
                            smask_next[wx] = smask_reg[ix];
                            slife_next[wx] = slife_reg[ix] - STEP;
                            wr_next        = wr_reg + 1'b1;
                        end
                    end
                end
                else if (out_free)
                begin
                    live_next              = wr_reg;
                    out_next               = '0;
                    out_next.status        = ST_AGED;
                    out_next.removed_count = 5'(rem_reg);
                    out_next.live_count    = 5'(wr_reg);
                    out_next.last          = 1'b1;
                    out_vld_next           = 1'b1;
                end
            end
            BK_APORT:
            begin
                if (out_free)
                begin
                    idx_next = '0;
                    rec_next = '0;
                    if (pcnt_reg[cur_port] == '0)
                    begin
                        // stub: interface's own subnet, no router
                        out_next             = '0;
                        out_next.status      = ST_ADVERT;
                        out_next.adv_network = port_addr[cur_port] & port_mask[cur_port];
                        out_next.adv_netmask = port_mask[cur_port];
                        out_next.live_count  = 5'(live_reg);
                        out_next.last        = last_port;
                        out_vld_next         = 1'b1;
                        if (!last_port)
                        begin
                            port_next = port_reg + 1'b1;
                        end
                    end
                end
            end
            BK_ASCAN:
            begin
                if (out_free)
                begin
                    if (at_end)
                    begin
                        if (!last_port)
                        begin
                            port_next = port_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (nbr_match)
                        begin
                            out_next             = '0;
                            out_next.status      = ST_ADVERT;
                            out_next.adv_network = saddr_reg[ix] & smask_reg[ix];
                            out_next.adv_netmask = smask_reg[ix];
                            out_next.adv_router  = sid_reg[ix];
                            out_next.live_count  = 5'(live_reg);
                            out_next.last        = final_rec;
                            out_vld_next         = 1'b1;
                            rec_next             = rec_reg + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            valid_reg   <= '0;
            live_reg    <= '0;
            out_vld_reg <= 1'b0;
            for (int p = 0; p < 4; p++)
            begin
                pcnt_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            live_reg    <= live_next;
            out_vld_reg <= out_vld_next;
            pcnt_reg    <= pcnt_next;
        end
    end

    // slot contents are only read behind a valid bit
    always_ff @(posedge clk)
    begin
        sport_reg <= sport_next;
        sid_reg   <= sid_next;
        saddr_reg <= saddr_next;
        smask_reg <= smask_next;
        slife_reg <= slife_next;
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        wr_reg    <= wr_next;
        rem_reg   <= rem_next;
        rec_reg   <= rec_next;
        port_reg  <= port_next;
        out_reg   <= out_next;
    end
endmodule
`default_nettype wire

### rtl/neighbor_table_with_aging.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir  | Payload
// cmd     | sink | func, port_index, sender_id, sender_addr, sender_netmask
// res     | src  | status, adv_*, removed_count, live_count, last
// cfg     | sink | index 0..7, wdata (port address / netmask)
// Each cmd passes through the queue to the back end, which walks the slots:
// Hello: walks to a matching slot (refresh) or the end (add, or drop when full); a bad port drops.
// Tick: walks every slot; the slot walk compacts the table in place.
// Advert: per port, one record for each of its neighbors, or one stub record if it has none.
// A held res record stalls hello and advert walks; a tick stalls only at its end.
// Reset clears all valid bits and counters at once; no clearing pass.
// A two-entry queue lets cmd accept up to two items while the back end or res is stalled.
module neighbor_table_with_aging
    import nta_pkg::*;
#(
    parameter int NEIGHBORS      = NtaNeighbors,
    parameter int PORTS          = NtaPorts,
    parameter int HELLO_INTERVAL = NtaHelloInterval,
    parameter int AGE_STEP       = NtaAgeStep
) (
    input wire logic clk,
    input wire logic rst_n,
    nta_in_if.sink   cmd,
    nta_out_if.source res,
    nta_cfg_if.sink  cfg
);
    `include "neighbor_table_with_aging_assert.svh"

    logic [31:0] port_addr_reg [4];
    logic [31:0] port_mask_reg [4];
    logic        q_valid, q_pop, busy;
    cmd_t        q_data;

    assign cfg.ready = 1'b1;

    // Register index: bit 0 picks mask, upper bits pick the port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < 4; p++)
            begin
                port_addr_reg[p] <= '0;
                port_mask_reg[p] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            if (cfg.index[0])
            begin
                port_mask_reg[cfg.index[2:1]] <= cfg.wdata;
            end
            else
            begin
                port_addr_reg[cfg.index[2:1]] <= cfg.wdata;
            end
        end
    end

    nta_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .in_data  (cmd.data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data)
    );

    nta_back #(
        .NEIGHBORS      (NEIGHBORS),
        .PORTS          (PORTS),
        .HELLO_INTERVAL (HELLO_INTERVAL),
        .AGE_STEP       (AGE_STEP)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .port_addr (port_addr_reg),
        .port_mask (port_mask_reg),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .res_data  (res.data),
        .busy      (busy)
    );

    `NTA_ASSERT_IMPL(a_pop_needs_item, clk, rst_n, q_pop, q_valid, "pop from empty queue")
    `NTA_ASSERT_IMPL(a_status_range, clk, rst_n, res.valid, res.data.status <= ST_ADVERT,
        "bad status")
    `NTA_ASSERT_NEXT(a_pop_busy, clk, rst_n, q_pop, busy, "back end idle after pop")
endmodule
`default_nettype wire
